FILE: src/lobm_pkg.sv
package lobm_pkg;
  localparam int ORDER_SLOTS = 32;
  localparam int PRICE_BITS = 20;
  localparam int QTY_BITS = 24;

  localparam logic [1:0] CMD_BUY = 2'd0;
  localparam logic [1:0] CMD_SELL = 2'd1;
  localparam logic [1:0] CMD_CANCEL = 2'd2;
  localparam logic [1:0] CMD_MODIFY = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_ID_ACTIVE = 3'd2;
  localparam logic [2:0] ST_ID_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_MOD_INACTIVE = 3'd4;

  localparam int MAX_TRADES = 31;

  typedef struct packed {
    logic load;
    logic seq_inc;
    logic scan_start;
    logic scan_step;
    logic do_trade;
    logic do_rest;
    logic do_cancel;
    logic emit_status;
    logic [2:0] status;
  } lobm_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic id_range_ok;
    logic params_ok;
    logic active;
    logic known;
    logic scan_done;
    logic best_found;
    logic cross_ok;
    logic taker_zero;
    logic trades_full;
    logic ioc;
    logic out_busy;
  } lobm_stat_t;
endpackage

FILE: src/lobm_datapath.sv
module lobm_datapath import lobm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  lobm_cmd_t ctl,
  output lobm_stat_t stat,
  input  logic [1:0] in_cmd,
  input  logic [4:0] in_id,
  input  logic in_ioc,
  input  logic in_side,
  input  logic [19:0] in_price,
  input  logic [23:0] in_qty,
  input  logic out_ready,
  output logic out_valid,
  output logic is_trade,
  output logic [4:0] resting_id,
  output logic [19:0] resting_price,
  output logic [4:0] taker_id,
  output logic [19:0] taker_price,
  output logic [23:0] trade_qty,
  output logic [2:0] status,
  output logic last
);
  localparam int IW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
  localparam int CW = $clog2(ORDER_SLOTS + 1);

  logic [ORDER_SLOTS-1:0] active;
  logic [ORDER_SLOTS-1:0] known;
  logic [ORDER_SLOTS-1:0] sside;
  logic [PRICE_BITS-1:0] sprice [ORDER_SLOTS];
  logic [QTY_BITS-1:0] sqty [ORDER_SLOTS];
  logic [31:0] sseq [ORDER_SLOTS];
  logic [31:0] seq_counter;

  logic [1:0] cmd;
  logic [4:0] tid;
  logic ioc;
  logic tside;
  logic [PRICE_BITS-1:0] tprice;
  logic [QTY_BITS-1:0] tqty;
  logic [31:0] tseq;
  logic [4:0] ntrades;

  logic [CW-1:0] scan;
  logic scan_end;
  logic pend;
  logic found;
  logic [IW-1:0] best;
  logic [PRICE_BITS-1:0] bprice;
  logic [QTY_BITS-1:0] bqty;
  logic [31:0] bseq;

  logic [IW-1:0] si;
  logic [IW-1:0] r_idx;
  logic r_elig;
  logic [PRICE_BITS-1:0] r_price;
  logic [QTY_BITS-1:0] r_qty;
  logic [31:0] r_seq;
  logic better;
  logic [IW-1:0] tidx;
  logic [QTY_BITS-1:0] q;

  assign si = scan[IW-1:0];
  assign scan_end = 32'(scan) >= ORDER_SLOTS;
  assign tidx = tid[IW-1:0];
  always_comb begin
    if (!found) better = 1'b1;
    else if (r_price == bprice) better = r_seq < bseq;
    else if (tside == 1'b0) better = r_price < bprice;
    else better = r_price > bprice;
  end
  assign q = (tqty < bqty) ? tqty : bqty;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      known <= '0;
      seq_counter <= '0;
      out_valid <= 1'b0;
      found <= 1'b0;
      pend <= 1'b0;
      scan <= '0;
    end else begin
      if (ctl.do_trade || ctl.emit_status) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (ctl.load) begin
        cmd <= in_cmd;
        tid <= in_id;
        ioc <= in_ioc;
        tside <= (in_cmd == CMD_MODIFY) ? in_side : in_cmd[0];
        tprice <= in_price[PRICE_BITS-1:0];
        tqty <= in_qty[QTY_BITS-1:0];
        ntrades <= '0;
      end
      if (ctl.seq_inc) begin
        tseq <= seq_counter;
        seq_counter <= seq_counter + 32'd1;
        if (cmd == CMD_MODIFY) active[tidx] <= 1'b0;
      end
      if (ctl.do_cancel) active[tidx] <= 1'b0;
      if (ctl.scan_start) begin
        scan <= '0;
        found <= 1'b0;
        pend <= 1'b0;
      end
      // read one slot per cycle, compare it on the next
      if (ctl.scan_step) begin
        if (!scan_end) begin
          r_idx <= si;
          r_elig <= active[si] && (sside[si] != tside);
          r_price <= sprice[si];
          r_qty <= sqty[si];
          r_seq <= sseq[si];
          scan <= scan + 1'b1;
        end
        pend <= !scan_end;
        if (pend && r_elig && (r_qty != '0) && better) begin
          found <= 1'b1;
          best <= r_idx;
          bprice <= r_price;
          bqty <= r_qty;
          bseq <= r_seq;
        end
      end
      if (ctl.do_trade) begin
        is_trade <= 1'b1;
        resting_id <= 5'(best);
        resting_price <= 20'(bprice);
        taker_id <= tid;
        taker_price <= 20'(tprice);
        trade_qty <= 24'(q);
        status <= ST_OK;
        last <= 1'b0;
        tqty <= tqty - q;
        sqty[best] <= bqty - q;
        if (bqty == q) active[best] <= 1'b0;
        ntrades <= ntrades + 5'd1;
      end
      if (ctl.do_rest) begin
        active[tidx] <= 1'b1;
        known[tidx] <= 1'b1;
        sside[tidx] <= tside;
        sprice[tidx] <= tprice;
        sqty[tidx] <= tqty;
        sseq[tidx] <= tseq;
      end
      if (ctl.emit_status) begin
        is_trade <= 1'b0;
        resting_id <= '0;
        resting_price <= '0;
        taker_id <= '0;
        taker_price <= '0;
        trade_qty <= '0;
        status <= ctl.status;
        last <= 1'b1;
      end
    end
  end

  always_comb begin
    stat.cmd = cmd;
    stat.id_range_ok = 32'(tid) < ORDER_SLOTS;
    stat.params_ok = (tprice != '0) && (tqty != '0);
    stat.active = active[tidx];
    stat.known = known[tidx];
    stat.scan_done = scan_end && !pend;
    stat.best_found = found;
    stat.cross_ok = (tside == 1'b0) ? !(tprice < bprice) : !(tprice > bprice);
    stat.taker_zero = tqty == '0;
    stat.trades_full = 32'(ntrades) >= MAX_TRADES;
    stat.ioc = ioc;
    stat.out_busy = out_valid && !out_ready;
  end
endmodule

FILE: src/lobm_ctrl.sv
module lobm_ctrl import lobm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  lobm_stat_t stat,
  output lobm_cmd_t ctl
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_REST = 3'd4;
  localparam logic [2:0] S_STATUS = 3'd5;

  logic [2:0] state, state_next;
  logic [2:0] st, st_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    st_next = st;
    ctl = '0;
    ctl.status = st;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        st_next = ST_OK;
        state_next = S_STATUS;
        if (!stat.id_range_ok) st_next = ST_ID_UNKNOWN;
        else if (stat.cmd == CMD_CANCEL) begin
          if (!stat.known) st_next = ST_ID_UNKNOWN;
          else ctl.do_cancel = 1'b1;
        end else if (!stat.params_ok) st_next = ST_INVALID;
        else if (stat.cmd == CMD_MODIFY) begin
          if (!stat.known) st_next = ST_ID_UNKNOWN;
          else if (!stat.active) st_next = ST_MOD_INACTIVE;
          else begin
            ctl.seq_inc = 1'b1;
            ctl.scan_start = 1'b1;
            state_next = S_SCAN;
          end
        end else if (stat.active) st_next = ST_ID_ACTIVE;
        else begin
          ctl.seq_inc = 1'b1;
          ctl.scan_start = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) state_next = S_DECIDE;
        else ctl.scan_step = 1'b1;
      end
      S_DECIDE: begin
        if (stat.taker_zero || stat.trades_full || !stat.best_found || !stat.cross_ok) begin
          state_next = S_REST;
        end else if (!stat.out_busy) begin
          ctl.do_trade = 1'b1;
          ctl.scan_start = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_REST: begin
        if (!stat.taker_zero && (!stat.ioc || stat.cmd == CMD_MODIFY)) ctl.do_rest = 1'b1;
        state_next = S_STATUS;
      end
      S_STATUS: begin
        if (!stat.out_busy) begin
          ctl.emit_status = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      st <= ST_OK;
    end else begin
      state <= state_next;
      st <= st_next;
    end
  end

`ifndef SYNTHESIS
  a_trade_not_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.do_trade |-> !in_ready) else $error("trade while idle");
  a_one_emit: assert property (@(posedge clk) disable iff (rst)
    !(ctl.do_trade && ctl.emit_status)) else $error("double emit");
  a_status_to_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.emit_status |=> in_ready) else $error("status not closing");
`endif
endmodule

FILE: src/limit_order_book_matcher.sv
// A rejected command or a cancel goes from the check state straight to its status.
// A buy, sell or modify runs a registered scan of all 32 slots and a decide step for each
// trade and for the final pass, then gives its status; output stalls lengthen this.
// Throughput: one command at a time, in_ready only while idle.
// Reset (rst, synchronous): all slots inactive and unknown, sequence counter zero, output empty.
module limit_order_book_matcher import lobm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] cmd,
  input  logic [4:0] order_id,
  input  logic ioc,
  input  logic side,
  input  logic [19:0] price,
  input  logic [23:0] qty,
  output logic out_valid,
  input  logic out_ready,
  output logic is_trade,
  output logic [4:0] resting_id,
  output logic [19:0] resting_price,
  output logic [4:0] taker_id,
  output logic [19:0] taker_price,
  output logic [23:0] trade_qty,
  output logic [2:0] status,
  output logic last
);
  lobm_cmd_t ctl;
  lobm_stat_t stat;

  lobm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .stat(stat), .ctl(ctl)
  );

  lobm_datapath u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .stat(stat),
    .in_cmd(cmd), .in_id(order_id), .in_ioc(ioc), .in_side(side),
    .in_price(price), .in_qty(qty), .out_ready(out_ready), .out_valid(out_valid),
    .is_trade(is_trade), .resting_id(resting_id), .resting_price(resting_price),
    .taker_id(taker_id), .taker_price(taker_price), .trade_qty(trade_qty),
    .status(status), .last(last)
  );
endmodule
